/* hw/rtl/hcbd_pkg.sv */
`default_nettype none

package hcbd_pkg;

  localparam int HCBD_SIZE_BITS  = 32;
  localparam int HCBD_FIFO_DEPTH = 4;

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } hcbd_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } hcbd_fifo_st_t;

endpackage

`default_nettype wire

/* hw/rtl/hcbd_front.sv */
`default_nettype none

module hcbd_front
  import hcbd_pkg::*;
#(
  parameter int SIZE_BITS = HCBD_SIZE_BITS
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       skip_header,
  input  wire logic       in_valid,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_start,
  output logic            res_valid,
  output hcbd_item_t      res
);

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_SIZE,
    PH_DATA,
    PH_TRAIL,
    PH_DONE
  } phase_t;

  phase_t                 phase, phase_next;
  logic [1:0]             header_match, header_match_next;
  logic [SIZE_BITS-1:0]   chunk_remaining, chunk_remaining_next;
  logic                   has_digit, has_digit_next;
  logic                   pending_cr, pending_cr_next;
  logic [1:0]             skip_left, skip_left_next;

  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [3:0] v;
    v = 4'h0;
    if (c inside {[8'h30:8'h39]}) begin
      v = 4'(c - 8'h30);
    end else if (c inside {[8'h61:8'h66]}) begin
      v = 4'(c - 8'h57);
    end else if (c inside {[8'h41:8'h46]}) begin
      v = 4'(c - 8'h37);
    end
    return v;
  endfunction

  always_comb begin
    logic [7:0] expect_byte;
    phase_next           = phase;
    header_match_next    = header_match;
    chunk_remaining_next = chunk_remaining;
    has_digit_next       = has_digit;
    pending_cr_next      = pending_cr;
    skip_left_next       = skip_left;
    res_valid            = 1'b0;
    res.data             = 8'h00;
    res.last             = 1'b0;

    if (in_start) begin
      phase_next           = skip_header ? PH_HEADER : PH_SIZE;
      header_match_next    = 2'd0;
      chunk_remaining_next = '0;
      has_digit_next       = 1'b0;
      pending_cr_next      = 1'b0;
      skip_left_next       = 2'd0;
    end

    expect_byte = header_match_next[0] ? CH_LF : CH_CR;

    case (phase_next)
      PH_HEADER: begin
        if (in_byte == expect_byte) begin
          if (header_match_next == 2'd3) begin
            header_match_next = 2'd0;
            phase_next        = PH_SIZE;
          end else begin
            header_match_next = header_match_next + 2'd1;
          end
        end else begin
          header_match_next = (in_byte == CH_CR) ? 2'd1 : 2'd0;
        end
      end
      PH_SIZE: begin
        if (pending_cr_next && in_byte == CH_LF) begin
          pending_cr_next = 1'b0;
          if (has_digit_next) begin
            has_digit_next = 1'b0;
            if (chunk_remaining_next == '0) begin
              phase_next = PH_DONE;
              res_valid  = 1'b1;
              res.last   = 1'b1;
            end else begin
              phase_next = PH_DATA;
            end
          end
        end else begin
          if (pending_cr_next) begin
            // A CR without LF behind it is a character worth digit zero.
            chunk_remaining_next = {chunk_remaining_next[SIZE_BITS-5:0], 4'h0};
            has_digit_next       = 1'b1;
            pending_cr_next      = 1'b0;
          end
          if (in_byte == CH_CR) begin
            pending_cr_next = 1'b1;
          end else begin
            chunk_remaining_next = {chunk_remaining_next[SIZE_BITS-5:0],
                                    hex_value(in_byte)};
            has_digit_next       = 1'b1;
          end
        end
      end
      PH_DATA: begin
        res_valid            = 1'b1;
        res.data             = in_byte;
        chunk_remaining_next = chunk_remaining_next - SIZE_BITS'(1);
        if (chunk_remaining_next == '0) begin
          phase_next     = PH_TRAIL;
          skip_left_next = 2'd2;
        end
      end
      PH_TRAIL: begin
        if (skip_left_next != 2'd0) begin
          skip_left_next = skip_left_next - 2'd1;
        end
        if (skip_left_next == 2'd0) begin
          phase_next           = PH_SIZE;
          chunk_remaining_next = '0;
          has_digit_next       = 1'b0;
          pending_cr_next      = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HEADER;
      header_match    <= 2'd0;
      chunk_remaining <= '0;
      has_digit       <= 1'b0;
      pending_cr      <= 1'b0;
      skip_left       <= 2'd0;
    end else if (in_valid) begin
      phase           <= phase_next;
      header_match    <= header_match_next;
      chunk_remaining <= chunk_remaining_next;
      has_digit       <= has_digit_next;
      pending_cr      <= pending_cr_next;
      skip_left       <= skip_left_next;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/hcbd_fifo.sv */
`default_nettype none

module hcbd_fifo
  import hcbd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  input  wire hcbd_item_t  push_item,
  input  wire logic        pop,
  output hcbd_item_t       pop_item,
  output hcbd_fifo_st_t    st
);

  localparam int PtrW = $clog2(HCBD_FIFO_DEPTH);
  localparam int CntW = $clog2(HCBD_FIFO_DEPTH + 1);

  hcbd_item_t            slots [HCBD_FIFO_DEPTH];
  logic [PtrW-1:0]       wr_ptr;
  logic [PtrW-1:0]       rd_ptr;
  logic [CntW-1:0]       count;
  logic                  do_push;
  logic                  do_pop;

  assign st.full   = (count == CntW'(HCBD_FIFO_DEPTH));
  assign st.empty  = (count == '0);
  assign do_push   = push && !st.full;
  assign do_pop    = pop && !st.empty;
  assign pop_item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(HCBD_FIFO_DEPTH - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(HCBD_FIFO_DEPTH - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CntW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/hcbd_out.sv */
`default_nettype none

module hcbd_out
  import hcbd_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire hcbd_fifo_st_t fifo_st,
  input  wire hcbd_item_t    fifo_item,
  output logic               pop,
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  output logic [7:0]         m_axis_tdata,
  output logic               m_axis_tlast
);

  assign pop = !fifo_st.empty && (!m_axis_tvalid || m_axis_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (pop) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      m_axis_tdata <= fifo_item.data;
      m_axis_tlast <= fifo_item.last;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/http_chunked_body_decoder.sv */
// HTTP chunked body decoder.
// The input stream carries one received byte per item on s_axis_tdata, with
// s_axis_tuser set on the first byte of a new response to restart decoding.
// The output stream carries each payload byte on m_axis_tdata; the item that
// marks the zero-size chunk has m_axis_tlast set and a zero data byte.
// The skip_header register is written through cfg_we and cfg_data; when set,
// header bytes up to the first blank line are dropped before chunk parsing.
// A new value applies at the next restart byte.
// One input item is taken every clock cycle while s_axis_tready is high; the
// decode state is updated as each byte is accepted. A result item is written
// into a small queue at the edge that accepts its byte and moves into the
// output register once that register is empty or being read by the receiver.
// Results leave at up to one per cycle.
// When the receiver stalls, results collect in the queue; s_axis_tready
// drops only when the queue is full, and resumes as soon as an entry drains.
// Reset clears the queue and the output, sets skip_header to 1 and puts the
// decoder in header skipping.
`default_nettype none

module http_chunked_body_decoder
  import hcbd_pkg::*;
#(
  parameter int SIZE_BITS = HCBD_SIZE_BITS
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic       cfg_data,        // skip_header
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,    // in_byte
  input  wire logic       s_axis_tuser,    // starts_message
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,    // out_byte
  output logic            m_axis_tlast
);

  logic          skip_header;
  logic          in_acc;
  logic          res_valid;
  hcbd_item_t    res;
  logic          push;
  logic          pop;
  hcbd_item_t    fifo_item;
  hcbd_fifo_st_t fifo_st;

  always_ff @(posedge clk) begin
    if (rst) begin
      skip_header <= 1'b1;
    end else if (cfg_we) begin
      skip_header <= cfg_data;
    end
  end

  assign s_axis_tready = !fifo_st.full;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign push          = in_acc && res_valid;

  hcbd_front #(
    .SIZE_BITS(SIZE_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .skip_header(skip_header),
    .in_valid   (in_acc),
    .in_byte    (s_axis_tdata),
    .in_start   (s_axis_tuser),
    .res_valid  (res_valid),
    .res        (res)
  );

  hcbd_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_item(res),
    .pop      (pop),
    .pop_item (fifo_item),
    .st       (fifo_st)
  );

  hcbd_out u_out (
    .clk          (clk),
    .rst          (rst),
    .fifo_st      (fifo_st),
    .fifo_item    (fifo_item),
    .pop          (pop),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  a_no_spurious_output: assert property (@(posedge clk) disable iff (rst)
    !push && fifo_st.empty && !m_axis_tvalid |=> !m_axis_tvalid)
    else $error("output became valid with nothing queued");

  a_result_reaches_output: assert property (@(posedge clk) disable iff (rst)
    push && fifo_st.empty && !m_axis_tvalid |=> !fifo_st.empty ##1 m_axis_tvalid)
    else $error("queued result did not reach the output register");

  a_end_has_zero_data: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tdata == 8'h00)
    else $error("end item carries a nonzero byte");

endmodule

`default_nettype wire
